/* hw/rtl/uv_sphere_vertex_generator_unit_defines.svh */
// assertion macros shared by the uv sphere vertex generator rtl
`ifndef UV_SPHERE_VERTEX_GENERATOR_UNIT_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define UVS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/uvs_pkg.sv */
// shared constants, types and helpers of the uv sphere vertex generator
`timescale 1ns / 1ps
`default_nettype none

package uvs_pkg;

  localparam int unsigned MAX_DIVISIONS    = 255;
  localparam int unsigned SINE_TABLE_DEPTH = 1024;

  localparam int unsigned DIV_W   = 8;
  localparam int unsigned RAD_W   = 15;
  // numerators of the phase and texture divisions fit 24 bits for depths up to 4096
  localparam int unsigned NUM_W   = 24;
  localparam int unsigned QUO_W   = 16;
  localparam int unsigned DEN_W   = 9;
  localparam int unsigned DIV_SPS = 4;
  localparam int unsigned SINE_W  = 15;
  localparam int unsigned POS_W   = 17;
  localparam int unsigned NRM_W   = 16;
  localparam int unsigned TEX_W   = 16;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned OUT_DATA_W = 136;

  typedef enum logic [KIND_W-1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_REJECT   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_LAT_DIV = 2'd0,
    REG_LON_DIV = 2'd1,
    REG_RADIUS  = 2'd2,
    REG_MODE    = 2'd3
  } reg_addr_e;

  typedef struct packed {
    logic                    reject;
    logic                    quad;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic [TEX_W-1:0]        tu;
    logic [TEX_W-1:0]        tv;
    logic [IDX_W-1:0]        i0;
    logic [IDX_W-1:0]        i1;
    logic [IDX_W-1:0]        i2;
    logic [IDX_W-1:0]        i3;
  } vtx_item_t;

  // round to nearest, ties away from zero
  function automatic logic signed [47:0] round_shift(input logic signed [47:0] v,
                                                    input int unsigned s);
    logic signed [47:0] half;
    half = 48'sd1 <<< (s - 1);
    if (v >= 0) begin
      return (v + half) >>> s;
    end else begin
      return -((-v + half) >>> s);
    end
  endfunction

  function automatic logic [DIV_W-1:0] clamp_div(input logic [DIV_W-1:0] v);
    if (v == '0) begin
      return DIV_W'(1);
    end else if (32'(v) > MAX_DIVISIONS) begin
      return DIV_W'(MAX_DIVISIONS);
    end else begin
      return v;
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/uvs_divider.sv */
// pipelined restoring divider, several quotient bits per stage
`timescale 1ns / 1ps
`default_nettype none

module uvs_divider #(
  parameter int unsigned NW  = uvs_pkg::NUM_W,
  parameter int unsigned DW  = uvs_pkg::DEN_W,
  parameter int unsigned QW  = uvs_pkg::QUO_W,
  parameter int unsigned SPS = uvs_pkg::DIV_SPS
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned NS   = QW / SPS;
  localparam int unsigned RemW = DW + 1;

  logic [RemW-1:0] rem_q [NS];
  logic [QW-1:0]   quo_q [NS];
  logic [QW-1:0]   low_q [NS];
  logic [DW-1:0]   den_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RemW-1:0] rem_in;
    logic [QW-1:0]   quo_in;
    logic [QW-1:0]   low_in;
    logic [DW-1:0]   den_in;
    logic [RemW-1:0] rem_d;
    logic [QW-1:0]   quo_d;
    logic [QW-1:0]   low_d;

    if (s == 0) begin : g_first
      assign rem_in = RemW'(num_i[NW-1:QW]);
      assign low_in = num_i[QW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    always_comb begin
      rem_d = rem_in;
      low_d = low_in;
      quo_d = quo_in;
      for (int j = 0; j < SPS; j++) begin
        rem_d = {rem_d[RemW-2:0], low_d[QW-1]};
        low_d = {low_d[QW-2:0], 1'b0};
        if (rem_d >= {1'b0, den_in}) begin
          rem_d = rem_d - {1'b0, den_in};
          quo_d = {quo_d[QW-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        low_q[s] <= low_d;
        quo_q[s] <= quo_d;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[NS-1];

endmodule

`default_nettype wire

/* hw/rtl/uvs_sine_rom.sv */
// quarter-wave sine rom in q1.14, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module uvs_sine_rom #(
  parameter int unsigned DEPTH = uvs_pkg::SINE_TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [$clog2(DEPTH+1)-1:0]    addr_a_i,
  input  logic [$clog2(DEPTH+1)-1:0]    addr_b_i,
  output logic [uvs_pkg::SINE_W-1:0]    data_a_o,
  output logic [uvs_pkg::SINE_W-1:0]    data_b_o
);
  import uvs_pkg::*;

  localparam logic [63:0] PiHalfQ30 = 64'd1686629713;
  localparam logic [63:0] SeriesDen [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};

  typedef logic [SINE_W-1:0] rom_t [DEPTH+1];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k <= int'(DEPTH); k++) begin
      x    = (PiHalfQ30 * 64'(k) + 64'(DEPTH / 2)) / 64'(DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / SeriesDen[n-1];
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      r[k] = SINE_W'((sum + 64'd32768) >> 16);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [SINE_W-1:0] data_a_q;
  logic [SINE_W-1:0] data_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= SineRom[addr_a_i];
      data_b_q <= SineRom[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

`default_nettype wire

/* hw/rtl/uvs_emitter.sv */
// result serializer: one vertex or reject result, then up to two triangles per grid point
`timescale 1ns / 1ps
`default_nettype none

`include "uv_sphere_vertex_generator_unit_defines.svh"

module uvs_emitter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  uvs_pkg::vtx_item_t                item_i,
  output logic                              ready_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // field_a, field_b, field_c, normal_x, normal_y, normal_z, tex_u, tex_v, zero pad
  output logic [uvs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // kind
  output logic [uvs_pkg::KIND_W-1:0]        m_axis_tuser,
  output logic                              m_axis_tlast
);
  import uvs_pkg::*;

  logic      busy_q;
  logic [1:0] cnt_q;
  vtx_item_t item_q;
  logic      last_res;
  logic      fire;

  kind_e                   kind;
  logic signed [POS_W-1:0] fa, fb, fc;
  logic signed [NRM_W-1:0] nx, ny, nz;
  logic [TEX_W-1:0]        tu, tv;
  logic                    lst;

  assign last_res = item_q.reject || !item_q.quad || (cnt_q == 2'd2);
  assign fire     = busy_q && m_axis_tready;
  assign ready_o  = !busy_q || (m_axis_tready && last_res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else if (ready_o) begin
      busy_q <= load_i;
      cnt_q  <= 2'd0;
    end else if (fire) begin
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      item_q <= item_i;
    end
  end

  always_comb begin
    kind = KIND_REJECT;
    lst  = 1'b1;
    fa   = '0;
    fb   = '0;
    fc   = '0;
    nx   = '0;
    ny   = '0;
    nz   = '0;
    tu   = '0;
    tv   = '0;
    if (!item_q.reject) begin
      case (cnt_q)
        2'd0: begin
          kind = KIND_VERTEX;
          lst  = !item_q.quad;
          fa   = item_q.px;
          fb   = item_q.py;
          fc   = item_q.pz;
          nx   = item_q.nx;
          ny   = item_q.ny;
          nz   = item_q.nz;
          tu   = item_q.tu;
          tv   = item_q.tv;
        end
        2'd1: begin
          kind = KIND_TRIANGLE;
          lst  = 1'b0;
          fa   = POS_W'(item_q.i0);
          fb   = POS_W'(item_q.i2);
          fc   = POS_W'(item_q.i1);
        end
        2'd2: begin
          kind = KIND_TRIANGLE;
          lst  = 1'b1;
          fa   = POS_W'(item_q.i1);
          fb   = POS_W'(item_q.i2);
          fc   = POS_W'(item_q.i3);
        end
        default: begin
          kind = KIND_REJECT;
          lst  = 1'b1;
        end
      endcase
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tuser  = kind;
  assign m_axis_tlast  = lst;
  assign m_axis_tdata  = {5'b0, tv, tu, nz, ny, nx, fc, fb, fa};

  `UVS_ASSERT_IMPL(a_cnt_range, busy_q, cnt_q != 2'd3, "result counter out of range")
  `UVS_ASSERT_IMPL(a_tri_only_quad, busy_q && (cnt_q != 2'd0), item_q.quad && !item_q.reject, "bad triangle")
  `UVS_ASSERT_NEXT(a_stall_hold, busy_q && !m_axis_tready, busy_q && $stable(cnt_q), "stall moved")

endmodule

`default_nettype wire

/* hw/rtl/uv_sphere_vertex_generator_unit.sv */
// top level of the uv sphere vertex generator
//
// channel   dir  handshake                    contents
// apb       in   psel/penable/pwrite/pready   four registers at 0x0, 0x4, 0x8, 0xc
// s_axis    in   tvalid/tready                grid point lat_index, lon_index
// m_axis    out  tvalid/tready                vertex, triangle or reject result
//
// a grid point can enter every cycle while the pipeline is not held; ten register stages
// to the serializer (stage 0, four divider stages, phase map, rom read, two multiply stages,
// rounding); the serializer sends one result per cycle while m_axis is ready: one result
// for a reject or edge vertex, three for a point that starts a cell, on the single result channel
// reset clears the valid and busy bits and loads the register defaults only; no table fill is needed
// a stall at m_axis holds the serializer; the pipeline holds while its full last stage waits on it
`timescale 1ns / 1ps
`default_nettype none

`include "uv_sphere_vertex_generator_unit_defines.svh"

module uv_sphere_vertex_generator_unit #(
  parameter int unsigned SINE_TABLE_DEPTH = uvs_pkg::SINE_TABLE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // lat_index, lon_index
  input  logic [15:0]                    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // field_a, field_b, field_c, normal_x, normal_y, normal_z, tex_u, tex_v, zero pad
  output logic [uvs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // kind
  output logic [uvs_pkg::KIND_W-1:0]     m_axis_tuser,
  output logic                           m_axis_tlast
);
  import uvs_pkg::*;

  localparam int unsigned AddrW     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned DivLat    = QUO_W / DIV_SPS;
  localparam int unsigned StOut     = DivLat + 5;
  localparam int unsigned NumStages = StOut + 1;
  localparam logic [15:0] D1 = 16'(SINE_TABLE_DEPTH);
  localparam logic [15:0] D2 = 16'(2 * SINE_TABLE_DEPTH);
  localparam logic [15:0] D3 = 16'(3 * SINE_TABLE_DEPTH);
  localparam logic [15:0] D4 = 16'(4 * SINE_TABLE_DEPTH);

  typedef struct packed {
    logic [DIV_W-1:0] lat;
    logic [DIV_W-1:0] lon;
    logic             reject;
    logic             quad;
  } ctl_t;

  typedef struct packed {
    logic             reject;
    logic             quad;
    logic [TEX_W-1:0] tu;
    logic [TEX_W-1:0] tv;
    logic [IDX_W-1:0] i0;
    logic [IDX_W-1:0] i1;
    logic [IDX_W-1:0] i2;
    logic [IDX_W-1:0] i3;
  } side_t;

  typedef struct packed {
    logic             neg;
    logic [AddrW-1:0] addr;
  } tap_t;

  function automatic tap_t phase_map(input logic [15:0] ph);
    logic [15:0] m;
    logic [15:0] r;
    logic [1:0]  q;
    tap_t        t;
    m = ph;
    if (m >= D4) begin
      m = m - D4;
    end
    if (m >= D3) begin
      q = 2'd3;
      r = m - D3;
    end else if (m >= D2) begin
      q = 2'd2;
      r = m - D2;
    end else if (m >= D1) begin
      q = 2'd1;
      r = m - D1;
    end else begin
      q = 2'd0;
      r = m;
    end
    t.neg  = q[1];
    t.addr = q[0] ? AddrW'(D1 - r) : AddrW'(r);
    return t;
  endfunction

  // configuration registers
  logic [DIV_W-1:0] lat_div_q;
  logic [DIV_W-1:0] lon_div_q;
  logic [RAD_W-1:0] radius_q;
  logic             mode_q;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_div_q <= DIV_W'(16);
      lon_div_q <= DIV_W'(32);
      radius_q  <= RAD_W'(4096);
      mode_q    <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_addr_e'(paddr[3:2]))
        REG_LAT_DIV: lat_div_q <= pwdata[DIV_W-1:0];
        REG_LON_DIV: lon_div_q <= pwdata[DIV_W-1:0];
        REG_RADIUS:  radius_q  <= pwdata[RAD_W-1:0];
        REG_MODE:    mode_q    <= pwdata[0];
        default:     mode_q    <= mode_q;
      endcase
    end
  end

  always_comb begin
    case (reg_addr_e'(paddr[3:2]))
      REG_LAT_DIV: prdata = 32'(lat_div_q);
      REG_LON_DIV: prdata = 32'(lon_div_q);
      REG_RADIUS:  prdata = 32'(radius_q);
      REG_MODE:    prdata = 32'(mode_q);
      default:     prdata = '0;
    endcase
  end

  logic [DIV_W-1:0] ld, nd;
  logic signed [15:0] rad;
  assign ld  = clamp_div(lat_div_q);
  assign nd  = clamp_div(lon_div_q);
  assign rad = mode_q ? $signed({1'b0, radius_q}) : 16'sd4096;

  // pipeline control
  logic [NumStages-1:0] valid_q;
  logic                 en;
  logic                 em_ready;

  assign en            = !valid_q[NumStages-1] || em_ready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumStages-2:0], s_axis_tvalid};
    end
  end

  // stage 0 and divider side pipe
  ctl_t             ctl_q [DivLat+1];
  logic [DIV_W-1:0] in_lat, in_lon;
  assign in_lat = s_axis_tdata[7:0];
  assign in_lon = s_axis_tdata[15:8];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0].lat    <= in_lat;
      ctl_q[0].lon    <= in_lon;
      ctl_q[0].reject <= (in_lat > ld) || (in_lon > nd);
      ctl_q[0].quad   <= (in_lat < ld) && (in_lon < nd);
      for (int k = 1; k <= int'(DivLat); k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  logic [NUM_W-1:0] num_t, num_p, num_u, num_v;
  logic [DEN_W-1:0] den_t, den_p;
  logic [QUO_W-1:0] ph_t, ph_p, tu_w, tt_w;

  assign num_t = NUM_W'(ctl_q[0].lat) * NUM_W'(4 * SINE_TABLE_DEPTH) + NUM_W'(ld);
  assign num_p = NUM_W'(ctl_q[0].lon) * NUM_W'(8 * SINE_TABLE_DEPTH) + NUM_W'(nd);
  assign num_u = {ctl_q[0].lon, 16'b0} + NUM_W'(nd);
  assign num_v = {ctl_q[0].lat, 16'b0} + NUM_W'(ld);
  assign den_t = {ld, 1'b0};
  assign den_p = {nd, 1'b0};

  uvs_divider u_div_t (.clk_i, .en_i(en), .num_i(num_t), .den_i(den_t), .quo_o(ph_t));
  uvs_divider u_div_p (.clk_i, .en_i(en), .num_i(num_p), .den_i(den_p), .quo_o(ph_p));
  uvs_divider u_div_u (.clk_i, .en_i(en), .num_i(num_u), .den_i(den_p), .quo_o(tu_w));
  uvs_divider u_div_v (.clk_i, .en_i(en), .num_i(num_v), .den_i(den_t), .quo_o(tt_w));

  // phase map, texture and index stage
  side_t            side_q [4];
  tap_t             tap_q [4];
  logic [16:0]      base, stride;
  ctl_t             ctl_d;

  assign ctl_d  = ctl_q[DivLat];
  assign stride = 17'(nd) + 17'd1;
  assign base   = 17'(ctl_d.lat) * stride + 17'(ctl_d.lon);

  always_ff @(posedge clk_i) begin
    if (en) begin
      tap_q[0] <= phase_map(ph_t);
      tap_q[1] <= phase_map(16'(ph_t + D1));
      tap_q[2] <= phase_map(ph_p);
      tap_q[3] <= phase_map(16'(ph_p + D1));
      side_q[0].reject <= ctl_d.reject;
      side_q[0].quad   <= ctl_d.quad;
      side_q[0].tu     <= tu_w;
      side_q[0].tv     <= mode_q ? 16'(17'd32768 - 17'(tt_w)) : tt_w;
      side_q[0].i0     <= base[15:0];
      side_q[0].i1     <= 16'(base + 17'd1);
      side_q[0].i2     <= 16'(base + stride);
      side_q[0].i3     <= 16'(base + stride + 17'd1);
      for (int k = 1; k < 4; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // rom read stage
  logic [SINE_W-1:0] sin_t_r, cos_t_r, sin_p_r, cos_p_r;
  logic [3:0]        neg_q;

  uvs_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom_t (
    .clk_i, .en_i(en), .addr_a_i(tap_q[0].addr), .addr_b_i(tap_q[1].addr),
    .data_a_o(sin_t_r), .data_b_o(cos_t_r));
  uvs_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom_p (
    .clk_i, .en_i(en), .addr_a_i(tap_q[2].addr), .addr_b_i(tap_q[3].addr),
    .data_a_o(sin_p_r), .data_b_o(cos_p_r));

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q <= {tap_q[3].neg, tap_q[2].neg, tap_q[1].neg, tap_q[0].neg};
    end
  end

  // first multiply stage
  logic signed [15:0] st, ct, sp, cp;
  logic signed [31:0] pc_q, ps_q, pyf_q;
  logic signed [15:0] ny_m_q;

  assign st = neg_q[0] ? -$signed({1'b0, sin_t_r}) : $signed({1'b0, sin_t_r});
  assign ct = neg_q[1] ? -$signed({1'b0, cos_t_r}) : $signed({1'b0, cos_t_r});
  assign sp = neg_q[2] ? -$signed({1'b0, sin_p_r}) : $signed({1'b0, sin_p_r});
  assign cp = neg_q[3] ? -$signed({1'b0, cos_p_r}) : $signed({1'b0, cos_p_r});

  always_ff @(posedge clk_i) begin
    if (en) begin
      pc_q   <= 32'(st) * 32'(cp);
      ps_q   <= 32'(st) * 32'(sp);
      pyf_q  <= 32'(rad) * 32'(ct);
      ny_m_q <= ct;
    end
  end

  // radius multiply and normal rounding stage
  logic signed [47:0]      pxf_q, pzf_q;
  logic signed [NRM_W-1:0] nx_q, ny_q, nz_q;
  logic signed [POS_W-1:0] py_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxf_q <= 48'(rad) * 48'(pc_q);
      pzf_q <= 48'(rad) * 48'(ps_q);
      nx_q  <= NRM_W'(round_shift(48'(pc_q), 14));
      nz_q  <= NRM_W'(round_shift(48'(ps_q), 14));
      py_q  <= POS_W'(round_shift(48'(pyf_q), 14));
      ny_q  <= ny_m_q;
    end
  end

  // final rounding and mode stage
  vtx_item_t item_q;
  logic      zero_n;
  assign zero_n = mode_q && (rad == 16'sd0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_q.reject <= side_q[3].reject;
      item_q.quad   <= side_q[3].quad;
      item_q.px     <= POS_W'(round_shift(pxf_q, 28));
      item_q.py     <= py_q;
      item_q.pz     <= POS_W'(round_shift(pzf_q, 28));
      item_q.nx     <= zero_n ? '0 : (mode_q ? nx_q : -nx_q);
      item_q.ny     <= zero_n ? '0 : (mode_q ? ny_q : -ny_q);
      item_q.nz     <= zero_n ? '0 : (mode_q ? nz_q : -nz_q);
      item_q.tu     <= side_q[3].tu;
      item_q.tv     <= side_q[3].tv;
      item_q.i0     <= side_q[3].i0;
      item_q.i1     <= side_q[3].i1;
      item_q.i2     <= side_q[3].i2;
      item_q.i3     <= side_q[3].i3;
    end
  end

  uvs_emitter u_emitter (
    .clk_i,
    .rst_ni,
    .load_i       (valid_q[NumStages-1]),
    .item_i       (item_q),
    .ready_o      (em_ready),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  `UVS_ASSERT_IMPL(a_empty_tail_ready, !valid_q[NumStages-1], s_axis_tready, "empty tail stall")
  `UVS_ASSERT_NEXT(a_tail_hold, valid_q[NumStages-1] && !em_ready, valid_q[NumStages-1], "point lost")
  `UVS_ASSERT_NEXT(a_in_enter, s_axis_tvalid && s_axis_tready, valid_q[0], "point not in stage 0")

endmodule

`default_nettype wire

/* sim/uv_sphere_vertex_generator_unit_checker.sv */
// result checker for the uv sphere vertex generator: predicts each grid point and compares
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_unit_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [135:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           fail_count,
  output int           pending_count
);
  import uvs_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic               last;
    logic signed [16:0] fa;
    logic signed [16:0] fb;
    logic signed [16:0] fc;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [15:0]        tu;
    logic [15:0]        tv;
  } mesh_out_t;

  localparam int unsigned D = SINE_TABLE_DEPTH;

  logic [15:0] sine_tab [0:D];
  logic [7:0]  lat_div_q, lon_div_q;
  logic [14:0] radius_q;
  logic        mode_q;
  mesh_out_t   mesh_q [$];

  initial begin
    longint unsigned pi_half, x, x2, term, sum;
    pi_half = 64'd1686629713;
    for (int k = 0; k <= D; k++) begin
      x = (pi_half * k + D / 2) / D;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n & 1) sum = sum - term;
        else sum = sum + term;
      end
      sine_tab[k] = 16'((sum + (64'd1 << 15)) >> 16);
    end
  end

  function automatic longint sine_at(longint unsigned ph);
    longint unsigned q, r;
    longint v;
    ph = ph % (4 * D);
    q = ph / D;
    r = ph % D;
    v = q[0] ? longint'(sine_tab[D - r]) : longint'(sine_tab[r]);
    return (q >= 2) ? -v : v;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint unsigned div_eff(logic [7:0] v);
    return (v == 0) ? 1 : longint'(v);
  endfunction

  task automatic predict_point(input logic [7:0] lat, input logic [7:0] lon);
    longint unsigned ld, nd, pht, php, tu, tt, stride, b;
    longint st, ct, sp, cp, rad, nx, ny, nz;
    mesh_out_t r;
    ld = div_eff(lat_div_q);
    nd = div_eff(lon_div_q);
    r = '0;
    if (lat > ld || lon > nd) begin
      r.kind = KIND_REJECT;
      r.last = 1'b1;
      mesh_q = {mesh_q, r};
      return;
    end
    pht = (lat * 4 * D + ld) / (2 * ld);
    php = (lon * 8 * D + nd) / (2 * nd);
    st = sine_at(pht);
    ct = sine_at(pht + D);
    sp = sine_at(php);
    cp = sine_at(php + D);
    rad = mode_q ? longint'(radius_q) : 4096;
    r.kind = KIND_VERTEX;
    r.fa = 17'(rnd_shift(rad * st * cp, 28));
    r.fb = 17'(rnd_shift(rad * ct, 14));
    r.fc = 17'(rnd_shift(rad * st * sp, 28));
    nx = rnd_shift(st * cp, 14);
    ny = ct;
    nz = rnd_shift(st * sp, 14);
    if (!mode_q) begin
      nx = -nx; ny = -ny; nz = -nz;
    end else if (rad == 0) begin
      nx = 0; ny = 0; nz = 0;
    end
    r.nx = 16'(nx);
    r.ny = 16'(ny);
    r.nz = 16'(nz);
    tu = (lon * 65536 + nd) / (2 * nd);
    tt = (lat * 65536 + ld) / (2 * ld);
    r.tu = 16'(tu);
    r.tv = 16'(mode_q ? 32768 - tt : tt);
    r.last = !(lat < ld && lon < nd);
    mesh_q = {mesh_q, r};
    if (r.last) return;
    stride = nd + 1;
    b = lat * stride + lon;
    r = '0;
    r.kind = KIND_TRIANGLE;
    r.fa = 17'(16'(b));
    r.fb = 17'(16'(b + stride));
    r.fc = 17'(16'(b + 1));
    mesh_q = {mesh_q, r};
    r.fa = 17'(16'(b + 1));
    r.fb = 17'(16'(b + stride));
    r.fc = 17'(16'(b + stride + 1));
    r.last = 1'b1;
    mesh_q = {mesh_q, r};
  endtask

  assign pending_count = mesh_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    mesh_out_t got, want;
    if (!rst_ni) begin
      lat_div_q <= 8'd16;
      lon_div_q <= 8'd32;
      radius_q <= 15'd4096;
      mode_q <= 1'b0;
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (reg_addr_e'(paddr[3:2]))
          REG_LAT_DIV: lat_div_q <= pwdata[7:0];
          REG_LON_DIV: lon_div_q <= pwdata[7:0];
          REG_RADIUS:  radius_q <= pwdata[14:0];
          REG_MODE:    mode_q <= pwdata[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_point(s_axis_tdata[7:0], s_axis_tdata[15:8]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.last = m_axis_tlast;
        got.fa = m_axis_tdata[16:0];
        got.fb = m_axis_tdata[33:17];
        got.fc = m_axis_tdata[50:34];
        got.nx = m_axis_tdata[66:51];
        got.ny = m_axis_tdata[82:67];
        got.nz = m_axis_tdata[98:83];
        got.tu = m_axis_tdata[114:99];
        got.tv = m_axis_tdata[130:115];
        if (mesh_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = mesh_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* sim/uv_sphere_vertex_generator_unit_test.sv */
// stimulus and verdict for the uv sphere vertex generator
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_unit_test;
  import uvs_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;
  int           fail_count, pending_count;
  logic [7:0]   lat_div_now, lon_div_now;
  bit           hold_off = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  uv_sphere_vertex_generator_unit dut (.*);
  uv_sphere_vertex_generator_unit_checker checker_u (.*);

  // receiver stall pattern
  initial begin
    int sel;
    forever begin
      @(negedge clk_i);
      sel = $urandom_range(0, 99);
      if (hold_off) m_axis_tready <= 1'b0;
      else m_axis_tready <= (sel < 70) || (sel >= 90);
    end
  end

  task automatic reg_write(input reg_addr_e a, input logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {a, 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == REG_LAT_DIV) lat_div_now = v[7:0];
    if (a == REG_LON_DIV) lon_div_now = v[7:0];
  endtask

  task automatic send_point(input logic [7:0] lat, input logic [7:0] lon);
    s_axis_tdata <= {lon, lat};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic random_phase(input int n);
    int burst;
    int unsigned ld, nd;
    burst = 0;
    ld = (lat_div_now == 0) ? 1 : lat_div_now;
    nd = (lon_div_now == 0) ? 1 : lon_div_now;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        pause_sender();
        burst = $urandom_range(1, 20);
      end
      burst--;
      if ($urandom_range(0, 9) < 8)
        send_point($urandom_range(0, ld), $urandom_range(0, nd));
      else
        send_point($urandom_range(0, 255), $urandom_range(0, 255));
    end
    wait_drain();
  endtask

  initial begin
    lat_div_now = 8'd16;
    lon_div_now = 8'd32;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // directed points at reset settings: poles, seam, rejects, extremes
    send_point(0, 0); send_point(16, 32); send_point(15, 31); send_point(8, 16);
    send_point(17, 0); send_point(0, 33); send_point(255, 255); send_point(16, 0);
    send_point(0, 32); send_point(4, 8);
    wait_drain();
    reg_write(REG_MODE, 1); reg_write(REG_RADIUS, 32767);
    send_point(0, 0); send_point(8, 8); send_point(16, 31); send_point(3, 5);
    wait_drain();
    reg_write(REG_RADIUS, 0);
    send_point(5, 7); send_point(16, 32);
    wait_drain();
    reg_write(REG_LAT_DIV, 0); reg_write(REG_LON_DIV, 0); reg_write(REG_RADIUS, 4096);
    send_point(0, 0); send_point(1, 1); send_point(1, 0); send_point(2, 0);
    wait_drain();
    reg_write(REG_LAT_DIV, 255); reg_write(REG_LON_DIV, 255);
    send_point(254, 254); send_point(255, 255); send_point(128, 170);
    wait_drain();
    // long receiver hold-off while the sender keeps offering points
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(40);
    join
    reg_write(REG_MODE, 0); reg_write(REG_LAT_DIV, 7); reg_write(REG_LON_DIV, 13);
    random_phase(60);
    reg_write(REG_MODE, 1); reg_write(REG_RADIUS, $urandom_range(0, 32767));
    reg_write(REG_LAT_DIV, 1); reg_write(REG_LON_DIV, 255);
    random_phase(50);
    reg_write(REG_LAT_DIV, 255); reg_write(REG_LON_DIV, 3);
    reg_write(REG_RADIUS, 21845);
    random_phase(50);
    reg_write(REG_MODE, 0); reg_write(REG_LAT_DIV, 16); reg_write(REG_LON_DIV, 32);
    random_phase(50);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
